>>> hdl/svc_pkg.sv
`default_nettype none

package svc_pkg;

    localparam int COUNT_BITS = 12;
    localparam int COORD_BITS = 10;
    localparam int REPORT_BITS = 12;
    localparam int REG_BITS = 10;
    localparam int COLOR_BITS = 3;
    localparam int SAMPLE_BITS = 8;

    localparam int VSYNC_POS = 5;
    localparam int HSYNC_POS = 4;

    localparam int TDATA_BITS = 48;
    localparam int TUSER_BITS = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [REPORT_BITS-1:0] REPORT_MAX = {REPORT_BITS{1'b1}};

    localparam logic [REG_BITS-1:0] ACTIVE_WIDTH_RESET = REG_BITS'(900);
    localparam logic [REG_BITS-1:0] ACTIVE_HEIGHT_RESET = REG_BITS'(600);

    typedef enum logic [0:0] {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                   pixel_valid;
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [COLOR_BITS-1:0]  pixel_color;
        logic                   line_done;
        logic [REPORT_BITS-1:0] line_width;
        logic                   frame_done;
        logic [REPORT_BITS-1:0] frame_lines;
    } result_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

    function automatic logic [REPORT_BITS-1:0] report_sat(input logic [COUNT_BITS-1:0] v);
        logic [REPORT_BITS-1:0] r;
        if ({{REPORT_BITS{1'b0}}, v} > {{COUNT_BITS{1'b0}}, REPORT_MAX}) begin
            r = REPORT_MAX;
        end else begin
            r = REPORT_BITS'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/svc_in_stage.sv
`default_nettype none

module svc_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [svc_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  wire logic                           advance,
    output logic                                word_valid,
    output logic [svc_pkg::SAMPLE_BITS-1:0]     word_sample
);
    import svc_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   load;

    // The register may take a new word in the same cycle it hands one on.
    assign s_tready = !valid_reg || advance;
    assign load = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= s_tdata;
        end
    end

    assign word_valid = valid_reg;
    assign word_sample = sample_reg;

endmodule

`default_nettype wire

>>> hdl/svc_engine.sv
`default_nettype none

module svc_engine (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [svc_pkg::REG_BITS-1:0]    cfg_wdata,
    input  wire logic                           fire,
    input  wire logic [svc_pkg::SAMPLE_BITS-1:0] sample,
    output svc_pkg::result_t                     result
);
    import svc_pkg::*;

    logic [REG_BITS-1:0]   active_width_reg;
    logic [REG_BITS-1:0]   active_height_reg;

    logic [COUNT_BITS-1:0] pixel_count_reg;
    logic [COUNT_BITS-1:0] pixel_count_next;
    logic [COUNT_BITS-1:0] line_count_reg;
    logic [COUNT_BITS-1:0] line_count_next;
    logic                  in_line_reg;
    logic                  in_line_next;
    logic                  in_frame_reg;
    logic                  in_frame_next;
    logic                  prev_vsync_n_reg;
    logic                  prev_vsync_n_next;

    logic                  vsync_n;
    logic                  hsync_n;
    logic                  frame_start;
    logic                  frame_open;
    logic [COUNT_BITS-1:0] pc;
    logic [COUNT_BITS-1:0] lc;
    logic                  il;
    logic                  in_window;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_width_reg  <= ACTIVE_WIDTH_RESET;
            active_height_reg <= ACTIVE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_addr))
                REG_ACTIVE_WIDTH:  active_width_reg  <= cfg_wdata;
                REG_ACTIVE_HEIGHT: active_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        vsync_n = sample[VSYNC_POS];
        hsync_n = sample[HSYNC_POS];

        // A rising vsync_n opens a frame, and this sample already belongs to it.
        frame_start = !in_frame_reg && vsync_n && !prev_vsync_n_reg;
        frame_open  = in_frame_reg || frame_start;
        pc = frame_start ? '0 : pixel_count_reg;
        lc = frame_start ? '0 : line_count_reg;
        il = frame_start ? 1'b0 : in_line_reg;

        result = '0;
        pixel_count_next  = pixel_count_reg;
        line_count_next   = line_count_reg;
        in_line_next      = in_line_reg;
        in_frame_next     = in_frame_reg;
        prev_vsync_n_next = vsync_n;
        in_window         = 1'b0;

        if (frame_open) begin
            line_count_next = lc;
            in_frame_next   = 1'b1;
            if (!hsync_n) begin
                result.line_done  = il;
                result.line_width = il ? report_sat(pc) : '0;
                pixel_count_next  = '0;
                in_line_next      = 1'b0;
            end else begin
                in_line_next = 1'b1;
                if (pc == '0) begin
                    line_count_next = sat_inc(lc);
                end
                in_window =
                    ({{REG_BITS{1'b0}}, line_count_next} <=
                     {{COUNT_BITS{1'b0}}, active_height_reg}) &&
                    ({{REG_BITS{1'b0}}, pc} <
                     {{COUNT_BITS{1'b0}}, active_width_reg});
                if (in_window) begin
                    result.pixel_valid = 1'b1;
                    result.pixel_x     = pc[COORD_BITS-1:0];
                    result.pixel_y     = line_count_next[COORD_BITS-1:0];
                    result.pixel_color = sample[COLOR_BITS-1:0];
                end
                pixel_count_next = sat_inc(pc);
            end

            if (!vsync_n) begin
                result.frame_done  = 1'b1;
                result.frame_lines = report_sat(line_count_next);
                line_count_next    = '0;
                in_frame_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg  <= '0;
            line_count_reg   <= '0;
            in_line_reg      <= 1'b0;
            in_frame_reg     <= 1'b0;
            prev_vsync_n_reg <= 1'b1;
        end else if (fire) begin
            pixel_count_reg  <= pixel_count_next;
            line_count_reg   <= line_count_next;
            in_line_reg      <= in_line_next;
            in_frame_reg     <= in_frame_next;
            prev_vsync_n_reg <= prev_vsync_n_next;
        end
    end

    a_pixel_not_on_hsync_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.pixel_valid |-> !result.line_done)
        else $error("pixel write issued on a line end");

    a_pixel_row_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.pixel_valid |-> result.pixel_y != '0)
        else $error("pixel write on line zero");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.frame_done |=> line_count_reg == '0 && !in_frame_reg)
        else $error("frame end did not close the frame");

    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.line_done |=> pixel_count_reg == '0 && !in_line_reg)
        else $error("line end did not clear the pixel count");

endmodule

`default_nettype wire

>>> hdl/svc_out_stage.sv
`default_nettype none

module svc_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                word_valid,
    input  wire svc_pkg::result_t    word_result,
    output logic                     fire,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output svc_pkg::result_t         m_result
);
    import svc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A result moves in when the register is empty or being drained this cycle.
    assign fire = word_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= word_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

>>> hdl/sync_video_capture.sv
// Capture front end for a digital RGB video source. Each input word is one sampled
// byte (bit 5 vsync_n, bit 4 hsync_n, bits 2..0 blue, green, red) and yields exactly
// one output word carrying a frame-buffer write, a line-end report and a frame-end
// report, each qualified by its flag in m_tuser. A frame opens on the rising edge
// of vsync_n; lines are counted from 1. The block takes one word per clock while
// m_tready stays high: a word passes an input register, then the per-sample update
// of the pixel and line counters, then an output register, and the rate is set
// only by the downstream m_tready. active_width and active_height (register indexes
// 0 and 1) may be written only while no word is in flight.
`default_nettype none

module sync_video_capture (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [svc_pkg::REG_BITS-1:0]       cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample
    input  wire logic [svc_pkg::SAMPLE_BITS-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pixel_x, pixel_y, pixel_color, line_width, frame_lines, zero fill
    output logic [svc_pkg::TDATA_BITS-1:0]          m_tdata,
    // pixel_valid, line_done, frame_done
    output logic [svc_pkg::TUSER_BITS-1:0]          m_tuser
);
    import svc_pkg::*;

    logic                   word_valid;
    logic [SAMPLE_BITS-1:0] word_sample;
    logic                   fire;
    result_t                word_result;
    result_t                m_result;

    svc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (fire),
        .word_valid (word_valid),
        .word_sample(word_sample)
    );

    svc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .fire     (fire),
        .sample   (word_sample),
        .result   (word_result)
    );

    svc_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word_result(word_result),
        .fire       (fire),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    assign m_tdata = {
        1'b0,
        m_result.frame_lines,
        m_result.line_width,
        m_result.pixel_color,
        m_result.pixel_y,
        m_result.pixel_x
    };

    assign m_tuser = {
        m_result.frame_done,
        m_result.line_done,
        m_result.pixel_valid
    };

endmodule

`default_nettype wire
